FILE: rtl/tsf_pkg.sv
// Package for the touch sample filter: word types, codes and a shared helper.
// No dependencies; used by tsf_div, tsf_hist and touch_sample_filter.
package tsf_pkg;

	typedef struct packed {
		logic [11:0] raw_x;
		logic [11:0] raw_y;
		logic [11:0] raw_z1;
		logic [11:0] raw_z2;
		logic        pen_bit;
		logic [11:0] pressure_in;
		logic [31:0] tick_now;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] screen_x;
		logic [11:0] screen_y;
		logic [31:0] delta_ticks;
		logic [31:0] sample_time;
		logic [11:0] out_z1;
		logic [11:0] out_z2;
		logic        out_pen;
		logic [11:0] out_pressure;
		logic [15:0] sample_index;
	} out_word_t;

	typedef struct packed {
		logic clr;
		logic push;
	} hist_ctl_t;

	// history marks
	localparam logic [1:0] MARK_GOOD  = 2'd0;
	localparam logic [1:0] MARK_BAD   = 2'd1;
	localparam logic [1:0] MARK_EMPTY = 2'd2;

	// last pen state
	localparam logic [1:0] PEN_DOWN = 2'd0;
	localparam logic [1:0] PEN_UP   = 2'd1;
	localparam logic [1:0] PEN_NONE = 2'd3;

	// result status
	localparam logic [1:0] ST_REJECT = 2'd0;
	localparam logic [1:0] ST_STILL  = 2'd1;
	localparam logic [1:0] ST_DRAG   = 2'd2;
	localparam logic [1:0] ST_LIFT   = 2'd3;

	// register indexes
	localparam logic [2:0] REG_WIDTH  = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_LEFT   = 3'd2;
	localparam logic [2:0] REG_RIGHT  = 3'd3;
	localparam logic [2:0] REG_TOP    = 3'd4;
	localparam logic [2:0] REG_BOTTOM = 3'd5;
	localparam logic [2:0] REG_DEB    = 3'd6;
	localparam logic [2:0] REG_DRAG   = 3'd7;

	localparam int DIV_NW = 24;  // dividend / quotient width
	localparam int DIV_DW = 12;  // divisor width
	localparam int THR_W  = 14;  // outlier threshold width
	localparam int CNT_W  = 3;   // good-sample count width

	localparam logic [DIV_NW-1:0] JUMP_NUM = 24'd12288; // 3 px * 4096
	localparam logic [11:0]       RAW_MAX  = 12'd4095;

	function automatic logic jumped(input logic [11:0] ax, input logic [11:0] ay,
		input logic [11:0] bx, input logic [11:0] by,
		input logic [THR_W-1:0] tx, input logic [THR_W-1:0] ty);
		logic [11:0] dx;
		logic [11:0] dy;
		dx = (ax > bx) ? ax - bx : bx - ax;
		dy = (ay > by) ? ay - by : by - ay;
		return ({2'b00, dx} > tx) || ({2'b00, dy} > ty);
	endfunction

endpackage

FILE: rtl/tsf_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on tsf_pkg for widths.
module tsf_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [tsf_pkg::DIV_NW-1:0] dividend,
	input  logic [tsf_pkg::DIV_DW-1:0] divisor,
	output logic                      busy,
	output logic [tsf_pkg::DIV_NW-1:0] quotient
);
	localparam int NW = tsf_pkg::DIV_NW;
	localparam int DW = tsf_pkg::DIV_DW;
	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW:0]   rem_sh;
	logic [DW:0]   rem_sub;
	logic          ge;

	assign rem_sh  = {rem_q, quo_q[NW-1]};
	assign ge      = rem_sh >= {1'b0, divisor};
	assign rem_sub = rem_sh - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

FILE: rtl/tsf_hist.sv
// Sample history shift line with outlier marks and window sums.
// Depends on tsf_pkg for marks, control struct and the jump test.
module tsf_hist #(
	parameter int DEPTH = 11,
	parameter int WIN   = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tsf_pkg::hist_ctl_t          ctl,
	input  logic [11:0]                 new_x,
	input  logic [11:0]                 new_y,
	input  logic [tsf_pkg::THR_W-1:0]   tx,
	input  logic [tsf_pkg::THR_W-1:0]   ty,
	output logic                        new_bad,
	output logic [tsf_pkg::DIV_NW-1:0]  sum_x,
	output logic [tsf_pkg::DIV_NW-1:0]  sum_y,
	output logic [tsf_pkg::CNT_W-1:0]   cnt
);
	localparam int L = DEPTH - 1;

	logic [11:0] hx_q [DEPTH];
	logic [11:0] hy_q [DEPTH];
	logic [1:0]  hm_q [DEPTH];
	logic [1:0]  new_mark;
	logic [1:0]  re_mark;

	assign new_bad  = tsf_pkg::jumped(hx_q[L-1], hy_q[L-1], new_x, new_y, tx, ty);
	assign new_mark = new_bad ? tsf_pkg::MARK_BAD : tsf_pkg::MARK_GOOD;

	// previous entry is rechecked against the one before it
	always_comb begin
		re_mark = hm_q[L-1];
		if (hm_q[L-1] != tsf_pkg::MARK_EMPTY && hm_q[L-2] != tsf_pkg::MARK_EMPTY) begin
			re_mark = tsf_pkg::jumped(hx_q[L-1], hy_q[L-1], hx_q[L-2], hy_q[L-2], tx, ty)
				? tsf_pkg::MARK_BAD : tsf_pkg::MARK_GOOD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				hx_q[i] <= '0;
				hy_q[i] <= '0;
				hm_q[i] <= tsf_pkg::MARK_EMPTY;
			end
		end else if (ctl.clr) begin
			for (int i = 0; i < DEPTH; i++) begin
				hx_q[i] <= '0;
				hy_q[i] <= '0;
				hm_q[i] <= tsf_pkg::MARK_EMPTY;
			end
		end else if (ctl.push) begin
			for (int i = 0; i < L - 1; i++) begin
				hx_q[i] <= hx_q[i+1];
				hy_q[i] <= hy_q[i+1];
				hm_q[i] <= hm_q[i+1];
			end
			hx_q[L-2] <= hx_q[L-1];
			hy_q[L-2] <= hy_q[L-1];
			hm_q[L-2] <= re_mark;
			hx_q[L-1] <= new_x;
			hy_q[L-1] <= new_y;
			hm_q[L-1] <= new_mark;
			hx_q[L]   <= new_x;
			hy_q[L]   <= new_y;
			hm_q[L]   <= new_mark;
		end
	end

	// good samples with nonzero y among the newest WIN entries
	always_comb begin
		sum_x = '0;
		sum_y = '0;
		cnt   = '0;
		for (int i = L - WIN; i < L; i++) begin
			if (hm_q[i] == tsf_pkg::MARK_GOOD && hy_q[i] != 12'd0) begin
				sum_x = sum_x + tsf_pkg::DIV_NW'(hx_q[i]);
				sum_y = sum_y + tsf_pkg::DIV_NW'(hy_q[i]);
				cnt   = cnt + 1'b1;
			end
		end
	end

endmodule

FILE: rtl/touch_sample_filter.sv
// Top level of the touch sample filter: sequencer, registers, output word.
// Depends on tsf_pkg, tsf_div and tsf_hist.
//
//  channel   direction  handshake            payload
//  in        input      in_valid / in_ready   in_data (in_word_t)
//  out       output     out_valid / out_ready out_data (out_word_t)
//  config    input      wr_en                 wr_index, wr_data
//
// A word passes from acceptance to the output register along one of several paths:
// a reported point, one whose x numerator is negative, an outlier, a clear or pen
// lift, or a word rejected after averaging; each divider pass goes through start,
// the 24 quotient bits and the result, with up to six passes per word.
// Input is taken only when the sequencer is idle, from the cycle after the load;
// a finished word waits in the output register while the next word is
// accepted, and a stalled output holds the sequencer in its last state.
// Reset empties the history at once; no clearing pass.
module touch_sample_filter #(
	parameter int HISTORY_DEPTH = 11,
	parameter int AVG_WINDOW    = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tsf_pkg::in_word_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tsf_pkg::out_word_t  out_data,
	input  logic                wr_en,
	input  logic [2:0]          wr_index,
	input  logic [15:0]         wr_data
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHECK = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_UPD   = 4'd3;
	localparam logic [3:0] S_SUM   = 4'd4;
	localparam logic [3:0] S_DEC   = 4'd5;
	localparam logic [3:0] S_MULX  = 4'd6;
	localparam logic [3:0] S_MULY  = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;

	localparam logic [2:0] OP_TX = 3'd0;
	localparam logic [2:0] OP_TY = 3'd1;
	localparam logic [2:0] OP_AX = 3'd2;
	localparam logic [2:0] OP_AY = 3'd3;
	localparam logic [2:0] OP_CX = 3'd4;
	localparam logic [2:0] OP_CY = 3'd5;

	localparam int NW = tsf_pkg::DIV_NW;
	localparam int TW = tsf_pkg::THR_W;
	localparam int CW = tsf_pkg::CNT_W;

	logic [11:0] width_q, height_q;
	logic [10:0] left_q, right_q, top_q, bottom_q;
	logic [15:0] deb_q, dwin_q;

	logic [3:0]  state_q;
	logic [2:0]  op_q;
	logic        go_q;
	tsf_pkg::in_word_t in_q;
	logic [11:0] prev_x_q, prev_y_q;
	logic [1:0]  prev_pen_q;
	logic [31:0] ref_time_q;
	logic [15:0] sample_count_q;
	logic        drag_active_q;
	logic [7:0]  drag_hits_q;
	logic [TW-1:0] tx_q, ty_q;
	logic [NW-1:0] sx_q, sy_q, prod_q;
	logic [CW-1:0] cnt_q;
	logic [11:0] ax_q, ay_q, cx_q, cy_q;
	logic [31:0] dt_q;
	logic [15:0] idx_q;
	logic [1:0]  st_q;
	tsf_pkg::out_word_t out_q;
	logic        out_valid_q;

	logic [11:0] ew, eh, hr, vr;
	logic [13:0] xdiff;
	logic [11:0] ydiff;
	logic [11:0] mul_a, mul_b;
	logic [NW-1:0] mul_p;
	logic [NW-1:0] div_num;
	logic [11:0]   div_den;
	logic          div_start, div_busy;
	logic [NW-1:0] div_quo;
	logic [11:0]   div_sat;
	tsf_pkg::hist_ctl_t hctl;
	logic          h_bad;
	logic [NW-1:0] h_sx, h_sy;
	logic [CW-1:0] h_cnt;
	logic          no_contact, lifted, pen_down;
	logic          drag, hit_two, in_area, report;
	logic [7:0]    hits_inc;
	logic          out_load;
	tsf_pkg::out_word_t out_d;

	assign ew = (width_q == 12'd0) ? 12'd1 : width_q;
	assign eh = (height_q == 12'd0) ? 12'd1 : height_q;
	// positive whenever the area test passes
	assign hr = tsf_pkg::RAW_MAX - {1'b0, left_q} - {1'b0, right_q};
	assign vr = tsf_pkg::RAW_MAX - {1'b0, top_q} - {1'b0, bottom_q};
	assign xdiff = {2'b00, tsf_pkg::RAW_MAX} - {3'b000, left_q} - {2'b00, ax_q};
	assign ydiff = ay_q - {1'b0, top_q};

	assign mul_a = (state_q == S_MULX) ? ew : eh;
	assign mul_b = (state_q == S_MULX) ? xdiff[11:0] : ydiff;
	assign mul_p = mul_a * mul_b;

	always_comb begin
		unique case (op_q)
			OP_TX: begin div_num = tsf_pkg::JUMP_NUM; div_den = ew; end
			OP_TY: begin div_num = tsf_pkg::JUMP_NUM; div_den = eh; end
			OP_AX: begin div_num = sx_q; div_den = 12'(cnt_q); end
			OP_AY: begin div_num = sy_q; div_den = 12'(cnt_q); end
			OP_CX: begin div_num = prod_q; div_den = hr; end
			OP_CY: begin div_num = prod_q; div_den = vr; end
			default: begin div_num = prod_q; div_den = 12'd1; end
		endcase
	end

	assign div_start = (state_q == S_DIV) && go_q;
	assign div_sat   = (div_quo[NW-1:12] != '0) ? tsf_pkg::RAW_MAX : div_quo[11:0];

	tsf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	assign no_contact = (in_q.pressure_in == 12'd0) && (prev_pen_q == {1'b0, in_q.pen_bit});
	assign lifted     = in_q.pen_bit && (prev_pen_q == tsf_pkg::PEN_DOWN);
	assign pen_down   = !in_q.pen_bit && (prev_pen_q == tsf_pkg::PEN_UP);

	assign hctl.clr  = (state_q == S_CHECK) && (no_contact || lifted || pen_down);
	assign hctl.push = (state_q == S_UPD);

	tsf_hist #(
		.DEPTH (HISTORY_DEPTH),
		.WIN   (AVG_WINDOW)
	) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (hctl),
		.new_x   (in_q.raw_x),
		.new_y   (in_q.raw_y),
		.tx      (tx_q),
		.ty      (ty_q),
		.new_bad (h_bad),
		.sum_x   (h_sx),
		.sum_y   (h_sy),
		.cnt     (h_cnt)
	);

	// drag: two moving samples inside the window, in a row or not, start a drag
	assign hits_inc = drag_hits_q + 8'd1;
	assign hit_two  = (dt_q < {16'd0, dwin_q}) && !drag_active_q
		&& (ax_q != prev_x_q) && (ay_q != prev_y_q);
	assign drag = (dt_q < {16'd0, dwin_q})
		&& (drag_active_q || (hit_two && hits_inc == 8'd2));
	assign report  = drag || (dt_q >= {16'd0, deb_q});
	assign in_area = (ay_q > {1'b0, top_q}) && (ay_q < tsf_pkg::RAW_MAX - {1'b0, bottom_q})
		&& (ax_q > {1'b0, left_q}) && (ax_q < tsf_pkg::RAW_MAX - {1'b0, right_q});

	always_comb begin
		out_d = '0;
		out_d.status       = st_q;
		out_d.out_z1       = in_q.raw_z1;
		out_d.out_z2       = in_q.raw_z2;
		out_d.out_pen      = in_q.pen_bit;
		out_d.out_pressure = in_q.pressure_in;
		if (st_q == tsf_pkg::ST_STILL || st_q == tsf_pkg::ST_DRAG) begin
			out_d.screen_x     = cx_q;
			out_d.screen_y     = cy_q;
			out_d.delta_ticks  = dt_q;
			out_d.sample_time  = in_q.tick_now;
			out_d.sample_index = idx_q;
		end
	end

	assign out_load = (state_q == S_FIN) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 12'd480;
			height_q <= 12'd272;
			left_q   <= 11'd210;
			right_q  <= 11'd210;
			top_q    <= 11'd255;
			bottom_q <= 11'd300;
			deb_q    <= 16'd20;
			dwin_q   <= 16'd100;
		end else if (wr_en) begin
			unique case (wr_index)
				tsf_pkg::REG_WIDTH:  width_q  <= wr_data[11:0];
				tsf_pkg::REG_HEIGHT: height_q <= wr_data[11:0];
				tsf_pkg::REG_LEFT:   left_q   <= wr_data[10:0];
				tsf_pkg::REG_RIGHT:  right_q  <= wr_data[10:0];
				tsf_pkg::REG_TOP:    top_q    <= wr_data[10:0];
				tsf_pkg::REG_BOTTOM: bottom_q <= wr_data[10:0];
				tsf_pkg::REG_DEB:    deb_q    <= wr_data;
				tsf_pkg::REG_DRAG:   dwin_q   <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			op_q           <= OP_TX;
			go_q           <= 1'b0;
			prev_x_q       <= '0;
			prev_y_q       <= '0;
			prev_pen_q     <= tsf_pkg::PEN_NONE;
			ref_time_q     <= '0;
			sample_count_q <= '0;
			drag_active_q  <= 1'b0;
			drag_hits_q    <= '0;
			st_q           <= tsf_pkg::ST_REJECT;
			out_valid_q    <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (no_contact || lifted) begin
						drag_active_q <= 1'b0;
						drag_hits_q   <= '0;
						prev_x_q      <= '0;
						prev_y_q      <= '0;
						prev_pen_q    <= tsf_pkg::PEN_NONE;
						ref_time_q    <= in_q.tick_now;
						st_q          <= no_contact ? tsf_pkg::ST_REJECT : tsf_pkg::ST_LIFT;
						state_q       <= S_FIN;
					end else begin
						if (pen_down) begin
							drag_active_q <= 1'b0;
							drag_hits_q   <= '0;
							ref_time_q    <= in_q.tick_now;
						end
						prev_x_q   <= in_q.raw_x;
						prev_y_q   <= in_q.raw_y;
						prev_pen_q <= {1'b0, in_q.pen_bit};
						op_q       <= OP_TX;
						go_q       <= 1'b1;
						state_q    <= S_DIV;
					end
				end
				S_DIV: begin
					if (go_q) begin
						go_q <= 1'b0;
					end else if (!div_busy) begin
						unique case (op_q)
							OP_TX: begin
								tx_q <= div_quo[TW-1:0];
								op_q <= OP_TY;
								go_q <= 1'b1;
							end
							OP_TY: begin
								ty_q    <= div_quo[TW-1:0];
								state_q <= S_UPD;
							end
							OP_AX: begin
								ax_q <= div_quo[11:0];
								op_q <= OP_AY;
								go_q <= 1'b1;
							end
							OP_AY: begin
								ay_q    <= div_quo[11:0];
								state_q <= S_DEC;
							end
							OP_CX: begin
								cx_q    <= div_sat;
								state_q <= S_MULY;
							end
							default: begin
								cy_q    <= div_sat;
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_UPD: begin
					if (h_bad) begin
						st_q    <= tsf_pkg::ST_REJECT;
						state_q <= S_FIN;
					end else begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					if (h_cnt == '0) begin
						st_q    <= tsf_pkg::ST_REJECT;
						state_q <= S_FIN;
					end else begin
						sx_q           <= h_sx;
						sy_q           <= h_sy;
						cnt_q          <= h_cnt;
						dt_q           <= in_q.tick_now - ref_time_q;
						ref_time_q     <= in_q.tick_now;
						idx_q          <= sample_count_q;
						sample_count_q <= sample_count_q + 16'd1;
						op_q           <= OP_AX;
						go_q           <= 1'b1;
						state_q        <= S_DIV;
					end
				end
				S_DEC: begin
					if (hit_two) begin
						drag_hits_q <= hits_inc;
						if (hits_inc == 8'd2) begin
							drag_active_q <= 1'b1;
						end
					end
					if (!report || !in_area) begin
						st_q    <= tsf_pkg::ST_REJECT;
						state_q <= S_FIN;
					end else begin
						st_q    <= drag ? tsf_pkg::ST_DRAG : tsf_pkg::ST_STILL;
						state_q <= S_MULX;
					end
				end
				S_MULX: begin
					// negative numerator truncates to zero
					if (xdiff[13]) begin
						cx_q    <= '0;
						state_q <= S_MULY;
					end else begin
						prod_q  <= mul_p;
						op_q    <= OP_CX;
						go_q    <= 1'b1;
						state_q <= S_DIV;
					end
				end
				S_MULY: begin
					prod_q  <= mul_p;
					op_q    <= OP_CY;
					go_q    <= 1'b1;
					state_q <= S_DIV;
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_q <= in_data;
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !div_busy)
		else $error("divider busy while sequencer idle");

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> !div_start)
		else $error("divider restarted while busy");

	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_CHECK)
		else $error("accepted word not checked");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == tsf_pkg::ST_REJECT
		|| out_data.status == tsf_pkg::ST_LIFT)
		|-> out_data.screen_x == 12'd0 && out_data.delta_ticks == 32'd0
		&& out_data.sample_index == 16'd0)
		else $error("position fields set on a non-position word");

endmodule
